>>> sv/oic_pkg.sv
// ----------------------------------------------------------------------------
// oic_pkg
// Shared types, constants and helpers of the invalid origin counter.
// ----------------------------------------------------------------------------
package oic_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TOP_K       = 5;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RANK_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [1:0] VS_VALID    = 2'd0;
    localparam logic [1:0] VS_INVALID  = 2'd1;
    localparam logic [1:0] VS_NOTFOUND = 2'd2;

    typedef enum logic [1:0] {
        OP_VALID,
        OP_INVALID,
        OP_NOTFOUND,
        OP_REPORT
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOOKUP,
        B_UPDATE,
        B_INCR,
        B_SCAN,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic        command;
        logic [1:0]  validation_state;
        logic [31:0] origin_asn;
    } oic_req_t;

    typedef struct packed {
        logic [2:0]  rank;
        logic [31:0] top_asn;
        logic [31:0] top_count;
        logic [31:0] valid_total;
        logic [31:0] invalid_total;
        logic [31:0] notfound_total;
        logic        table_full;
        logic        last;
    } oic_result_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] asn;
    } oic_job_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

>>> sv/invalid_origin_counter_top_k_unit.sv
// ----------------------------------------------------------------------------
// invalid_origin_counter_top_k_unit
// Counts route validation events per result and per invalid origin AS and
// reports the five busiest invalid origins on request.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high and busy is low; busy rises only
// when the four-entry job queue is full. Other events, and reports with no new
// events behind them, are settled in the front end and never reach the queue.
// Valid and not-found events take only the pop step in the table engine. An
// invalid event goes through pop, key match and insert when its origin is new,
// and through pop, key match, count read and count write back when the origin
// is already in the table; the engine pops no new job until the current one is
// done. A report with new events behind it gives five results, one cycle each
// on result_valid, with a scan of the filled table entries before each, read
// one entry at a time through the single read port of the key and count
// memories. Results cannot be held off by the receiver. The key and count
// tables need no clearing after reset.
module invalid_origin_counter_top_k_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  oic_pkg::oic_req_t    request,
    output logic                 result_valid,
    output oic_pkg::oic_result_t result
);
    import oic_pkg::*;

    logic     push;
    logic     full;
    logic     pop;
    logic     job_valid;
    oic_job_t job_in;
    oic_job_t job_out;

    assign busy = full;

    oic_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .full    (full),
        .request (request),
        .push    (push),
        .job     (job_in)
    );

    oic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .job_in    (job_in),
        .full      (full),
        .pop       (pop),
        .job_valid (job_valid),
        .job_out   (job_out)
    );

    oic_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job_out),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // results of one report are always separated by a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back result strobes");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.rank < RANK_W'(TOP_K)))
        else $error("report rank out of range");

    // a used entry always holds a count of at least one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.top_count == 32'd0)) |-> (result.top_asn == 32'd0))
        else $error("empty slot carries an AS number");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (result.rank == RANK_W'(TOP_K - 1)))
        else $error("last flag on wrong rank");

endmodule

>>> sv/oic_front.sv
// ----------------------------------------------------------------------------
// oic_front
// Takes requests, classifies them and tracks whether events are pending.
// ----------------------------------------------------------------------------
module oic_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              full,
    input  oic_pkg::oic_req_t request,
    output logic              push,
    output oic_pkg::oic_job_t job
);
    import oic_pkg::*;

    logic pending_reg;
    logic pending_next;
    logic accept;

    assign accept = start && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        push         = 1'b0;
        job.op       = OP_VALID;
        job.asn      = request.origin_asn;
        if (accept)
        begin
            case (request.command)
                CMD_REPORT:
                begin
                    // a report with nothing new is dropped here
                    push         = pending_reg;
                    job.op       = OP_REPORT;
                    pending_next = 1'b0;
                end
                default:
                begin
                    pending_next = 1'b1;
                    case (request.validation_state)
                        VS_VALID:
                        begin
                            push   = 1'b1;
                            job.op = OP_VALID;
                        end
                        VS_INVALID:
                        begin
                            push   = 1'b1;
                            job.op = OP_INVALID;
                        end
                        VS_NOTFOUND:
                        begin
                            push   = 1'b1;
                            job.op = OP_NOTFOUND;
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

>>> sv/oic_queue.sv
// ----------------------------------------------------------------------------
// oic_queue
// Short job queue between the classifying front end and the table engine.
// ----------------------------------------------------------------------------
module oic_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  oic_pkg::oic_job_t job_in,
    output logic              full,
    input  logic              pop,
    output logic              job_valid,
    output oic_pkg::oic_job_t job_out
);
    import oic_pkg::*;

    oic_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W:0]   wr_ptr_reg;
    logic [QPTR_W:0]   wr_ptr_next;
    logic [QPTR_W:0]   rd_ptr_reg;
    logic [QPTR_W:0]   rd_ptr_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (wr_ptr_reg[QPTR_W] != rd_ptr_reg[QPTR_W])
                    && (wr_ptr_reg[QPTR_W-1:0] == rd_ptr_reg[QPTR_W-1:0]);
    assign job_valid = (wr_ptr_reg != rd_ptr_reg);
    assign job_out   = slot_reg[rd_ptr_reg[QPTR_W-1:0]];
    assign do_push   = push && !full;
    assign do_pop    = pop && job_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg[QPTR_W-1:0]] <= job_in;
        end
    end

endmodule

>>> sv/oic_back.sv
// ----------------------------------------------------------------------------
// oic_back
// Table engine: totals, key match and insert, and the ranked report scan.
// ----------------------------------------------------------------------------
module oic_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  oic_pkg::oic_job_t    job,
    output logic                 job_pop,
    output logic                 result_valid,
    output oic_pkg::oic_result_t result
);
    import oic_pkg::*;

    back_state_t      state_reg, state_next;
    logic [31:0]      asn_reg, asn_next;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [31:0]      valid_tot_reg, valid_tot_next;
    logic [31:0]      invalid_tot_reg, invalid_tot_next;
    logic [31:0]      notfound_tot_reg, notfound_tot_next;
    logic             overflow_reg, overflow_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [TABLE_DEPTH-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_key_reg, best_key_next;
    logic [31:0]      best_count_reg, best_count_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    oic_result_t      result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic [31:0]      key_cam_reg [TABLE_DEPTH];
    logic [31:0]      key_mem [TABLE_DEPTH];
    logic [31:0]      count_mem [TABLE_DEPTH];
    logic [31:0]      key_rd_reg;
    logic [31:0]      count_rd_reg;

    logic             key_we;
    logic             count_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      count_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // parallel key match over the filled part of the table
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if ((CNT_W'(i) < entry_count_reg) && (key_cam_reg[i] == asn_reg))
            begin
                hit_any = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_cam_reg[mem_waddr] <= asn_reg;
            key_mem[mem_waddr]     <= asn_reg;
        end
        if (count_we)
        begin
            count_mem[mem_waddr] <= count_wdata;
        end
        if (mem_re)
        begin
            key_rd_reg   <= key_mem[mem_raddr];
            count_rd_reg <= count_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        asn_next          = asn_reg;
        entry_count_next  = entry_count_reg;
        valid_tot_next    = valid_tot_reg;
        invalid_tot_next  = invalid_tot_reg;
        notfound_tot_next = notfound_tot_reg;
        overflow_next     = overflow_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        taken_next        = taken_reg;
        scan_addr_next    = scan_addr_reg;
        rd_valid_next     = 1'b0;
        rd_idx_next       = rd_idx_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_key_next     = best_key_reg;
        best_count_next   = best_count_reg;
        rank_next         = rank_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        job_pop           = 1'b0;
        key_we            = 1'b0;
        count_we          = 1'b0;
        mem_waddr         = hit_idx_reg;
        count_wdata       = 32'd1;
        mem_re            = 1'b0;
        mem_raddr         = hit_idx_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop  = 1'b1;
                    asn_next = job.asn;
                    case (job.op)
                        OP_VALID:
                        begin
                            valid_tot_next = sat_inc(valid_tot_reg);
                        end
                        OP_NOTFOUND:
                        begin
                            notfound_tot_next = sat_inc(notfound_tot_reg);
                        end
                        OP_INVALID:
                        begin
                            invalid_tot_next = sat_inc(invalid_tot_reg);
                            state_next       = B_LOOKUP;
                        end
                        default:
                        begin
                            taken_next     = '0;
                            rank_next      = '0;
                            scan_addr_next = '0;
                            found_next     = 1'b0;
                            state_next     = B_SCAN;
                        end
                    endcase
                end
            end
            B_LOOKUP:
            begin
                hit_next     = hit_any;
                hit_idx_next = hit_idx;
                state_next   = B_UPDATE;
            end
            B_UPDATE:
            begin
                state_next = B_IDLE;
                if (hit_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = hit_idx_reg;
                    state_next = B_INCR;
                end
                else if (entry_count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    key_we           = 1'b1;
                    count_we         = 1'b1;
                    mem_waddr        = entry_count_reg[IDX_W-1:0];
                    count_wdata      = 32'd1;
                    entry_count_next = entry_count_reg + 1'b1;
                end
            end
            B_INCR:
            begin
                count_we    = 1'b1;
                mem_waddr   = hit_idx_reg;
                count_wdata = sat_inc(count_rd_reg);
                state_next  = B_IDLE;
            end
            B_SCAN:
            begin
                if (scan_addr_reg != entry_count_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg[IDX_W-1:0];
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    state_next = B_EMIT;
                end
                // strict compare keeps the earlier entry on a tie
                if (rd_valid_reg && !taken_reg[rd_idx_reg]
                    && (!found_reg || (count_rd_reg > best_count_reg)))
                begin
                    found_next      = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_key_next   = key_rd_reg;
                    best_count_next = count_rd_reg;
                end
            end
            B_EMIT:
            begin
                result_valid_next          = 1'b1;
                result_next.rank           = rank_reg;
                result_next.top_asn        = found_reg ? best_key_reg : 32'd0;
                result_next.top_count      = found_reg ? best_count_reg : 32'd0;
                result_next.valid_total    = valid_tot_reg;
                result_next.invalid_total  = invalid_tot_reg;
                result_next.notfound_total = notfound_tot_reg;
                result_next.table_full     = overflow_reg;
                result_next.last           = (rank_reg == RANK_W'(TOP_K - 1));
                if (found_reg)
                begin
                    taken_next[best_idx_reg] = 1'b1;
                end
                if (rank_reg == RANK_W'(TOP_K - 1))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    rank_next      = rank_reg + 1'b1;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    state_next     = B_SCAN;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            entry_count_reg  <= '0;
            valid_tot_reg    <= '0;
            invalid_tot_reg  <= '0;
            notfound_tot_reg <= '0;
            overflow_reg     <= 1'b0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            valid_tot_reg    <= valid_tot_next;
            invalid_tot_reg  <= invalid_tot_next;
            notfound_tot_reg <= notfound_tot_next;
            overflow_reg     <= overflow_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asn_reg        <= asn_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        taken_reg      <= taken_next;
        scan_addr_reg  <= scan_addr_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        best_count_reg <= best_count_next;
        rank_reg       <= rank_next;
        result_reg     <= result_next;
    end

endmodule

>>> verif/invalid_origin_counter_top_k_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// invalid_origin_counter_top_k_unit_tb
// Drives count and report requests into the invalid origin counter, with
// random idle bursts, and checks every report row against a behavioural
// ledger of per-origin counts and totals kept inside the testbench.
// ----------------------------------------------------------------------------
module invalid_origin_counter_top_k_unit_tb;

    import oic_pkg::*;

    localparam logic [1:0]  VS_OTHER     = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned SETTLE_WAIT  = 400;
    localparam int unsigned RANDOM_COUNT = 330;
    localparam int unsigned CALM_TAIL    = 40;

    class origin_ledger;
        logic [31:0]  keys [TABLE_DEPTH];
        logic [31:0]  counts [TABLE_DEPTH];
        int unsigned  used = 0;
        logic [31:0]  valid_sum = '0;
        logic [31:0]  invalid_sum = '0;
        logic [31:0]  notfound_sum = '0;
        bit           fresh_events = 1'b0;
        bit           dropped = 1'b0;
        oic_result_t  report_rows[$];
        int unsigned  mismatches = 0;

        function logic [31:0] plus_one_sat(input logic [31:0] v);
            return v + {31'd0, ~&v};
        endfunction

        function void log_invalid(input logic [31:0] asn);
            for (int i = 0; i < used; i++)
            begin
                if (keys[i] == asn)
                begin
                    counts[i] = plus_one_sat(counts[i]);
                    return;
                end
            end
            if (used >= TABLE_DEPTH)
            begin
                dropped = 1'b1;
                return;
            end
            keys[used] = asn;
            counts[used] = 32'd1;
            used++;
        endfunction

        function void queue_report();
            bit          taken [TABLE_DEPTH];
            oic_result_t row;
            int          best;
            for (int i = 0; i < TABLE_DEPTH; i++)
                taken[i] = 1'b0;
            for (int r = 0; r < TOP_K; r++)
            begin
                best = -1;
                for (int i = 0; i < used; i++)
                begin
                    if (!taken[i] && (best < 0 || counts[i] > counts[best]))
                        best = i;
                end
                row.rank = 3'(r);
                if (best >= 0)
                begin
                    taken[best] = 1'b1;
                    row.top_asn = keys[best];
                    row.top_count = counts[best];
                end
                else
                begin
                    row.top_asn = '0;
                    row.top_count = '0;
                end
                row.valid_total = valid_sum;
                row.invalid_total = invalid_sum;
                row.notfound_total = notfound_sum;
                row.table_full = dropped;
                row.last = (r == TOP_K - 1);
                report_rows.push_back(row);
            end
            fresh_events = 1'b0;
        endfunction

        function void note_request(input oic_req_t req);
            if (req.command == CMD_REPORT)
            begin
                if (fresh_events)
                    queue_report();
                return;
            end
            case (req.validation_state)
                VS_VALID:    valid_sum = plus_one_sat(valid_sum);
                VS_INVALID:
                begin
                    invalid_sum = plus_one_sat(invalid_sum);
                    log_invalid(req.origin_asn);
                end
                VS_NOTFOUND: notfound_sum = plus_one_sat(notfound_sum);
                default:     ;
            endcase
            fresh_events = 1'b1;
        endfunction

        function void compare(input string name, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input oic_result_t got);
            oic_result_t want;
            if (report_rows.size() == 0)
            begin
                $error("report row with none expected: rank %0d asn %0h",
                       got.rank, got.top_asn);
                mismatches++;
                return;
            end
            want = report_rows.pop_front();
            compare("rank", 32'(want.rank), 32'(got.rank));
            compare("top_asn", want.top_asn, got.top_asn);
            compare("top_count", want.top_count, got.top_count);
            compare("valid_total", want.valid_total, got.valid_total);
            compare("invalid_total", want.invalid_total, got.invalid_total);
            compare("notfound_total", want.notfound_total, got.notfound_total);
            compare("table_full", 32'(want.table_full), 32'(got.table_full));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction

        function int unsigned outstanding();
            return report_rows.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    oic_req_t    request;
    logic        result_valid;
    oic_result_t result;

    origin_ledger ledger;
    int unsigned  cycles;
    logic [31:0]  hot_asns [6];

    invalid_origin_counter_top_k_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            ledger.check_result(result);
    end

    // one request, held until the block takes it
    task automatic issue(input oic_req_t req, input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_request(req);
    endtask

    function automatic oic_req_t make_req(input logic cmd, input logic [1:0] vs,
                                          input logic [31:0] asn);
        oic_req_t req;
        req.command = cmd;
        req.validation_state = vs;
        req.origin_asn = asn;
        return req;
    endfunction

    function automatic oic_req_t random_req();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 7)
            return make_req(CMD_REPORT, 2'($urandom_range(0, 3)), $urandom);
        if (pick < 22)
            return make_req(CMD_COUNT, VS_VALID, $urandom);
        if (pick < 62)
        begin
            if ($urandom_range(0, 9) < 4)
                return make_req(CMD_COUNT, VS_INVALID, hot_asns[$urandom_range(0, 5)]);
            return make_req(CMD_COUNT, VS_INVALID, $urandom);
        end
        if (pick < 80)
            return make_req(CMD_COUNT, VS_NOTFOUND, $urandom);
        return make_req(CMD_COUNT, VS_OTHER, $urandom);
    endfunction

    initial
    begin
        int unsigned gap;
        bit          idling;
        ledger = new();
        hot_asns[0] = 32'h0000_0000;
        hot_asns[1] = 32'hFFFF_FFFF;
        hot_asns[2] = 32'h0000_FDE8;
        hot_asns[3] = 32'h0001_0001;
        hot_asns[4] = $urandom;
        hot_asns[5] = $urandom;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part
        issue(make_req(CMD_REPORT, VS_OTHER, 32'hFFFF_FFFF), 0);
        issue(make_req(CMD_COUNT, VS_VALID, 32'h0), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h0000_0000), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'hFFFF_FFFF), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h0000_0000), 0);
        issue(make_req(CMD_COUNT, VS_NOTFOUND, 32'hFFFF_FFFF), 0);
        issue(make_req(CMD_COUNT, VS_OTHER, $urandom), 0);
        issue(make_req(CMD_REPORT, VS_VALID, 32'h0), 0);
        issue(make_req(CMD_REPORT, VS_INVALID, 32'h1234_5678), 0);
        issue(make_req(CMD_COUNT, VS_OTHER, 32'h0), 3);
        issue(make_req(CMD_REPORT, VS_NOTFOUND, 32'h0), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h1234_5678), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'hFFFF_FFFF), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'hA5A5_A5A5), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h5A5A_5A5A), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h8000_0001), 0);
        issue(make_req(CMD_COUNT, VS_INVALID, 32'h7FFF_FFFE), 0);
        issue(make_req(CMD_REPORT, VS_OTHER, 32'hFFFF_FFFF), 0);
        issue(make_req(CMD_COUNT, VS_VALID, 32'h0), 0);
        issue(make_req(CMD_REPORT, VS_VALID, 32'h0), 0);

        // random part, idling in some stretches only
        for (int k = 0; k < RANDOM_COUNT; k++)
        begin
            idling = ((k / 40) % 3 != 1) && (k < RANDOM_COUNT - CALM_TAIL);
            gap = 0;
            if (idling && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 19);
            if (k == RANDOM_COUNT / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (ledger.outstanding() != 0)
                    @(posedge clk);
            end
            issue(random_req(), gap);
        end
        issue(make_req(CMD_REPORT, VS_OTHER, $urandom), 0);

        start <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/oic_pkg.sv
sv/oic_front.sv
sv/oic_queue.sv
sv/oic_back.sv
sv/invalid_origin_counter_top_k_unit.sv
verif/invalid_origin_counter_top_k_unit_tb.sv
